@@ src/dhfs_pkg.sv @@
// Package for the DCT high-frequency smoothing block: sizes, codes, command
// and status structs, and the DCT basis table.
// No dependencies.
`default_nettype none

package dhfs_pkg;

  localparam int BLOCK_SIDE    = 8;
  localparam int SIDE_W        = $clog2(BLOCK_SIDE);
  localparam int BLOCK_AREA    = BLOCK_SIDE * BLOCK_SIDE;
  localparam int POS_W         = $clog2(BLOCK_AREA);
  localparam int PIX_W         = 8;
  localparam int COS_FRAC_BITS = 14;
  localparam int GUARD_BITS    = 4;
  localparam int COEF_W        = COS_FRAC_BITS + 2;
  localparam int WORK_W        = 24;
  localparam int PROD_W        = WORK_W + COEF_W;
  localparam int ACC_W         = PROD_W + SIDE_W;

  // rounding shifts of the passes (SH_INV serves both inverse passes)
  localparam int SH_ROW = COS_FRAC_BITS + 2 - GUARD_BITS;
  localparam int SH_COL = COS_FRAC_BITS + 2;
  localparam int SH_INV = COS_FRAC_BITS;

  // configuration
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HF_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND    = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET    = 9'd154;

  typedef enum logic [1:0] {
    PASS_ROW,
    PASS_COL,
    PASS_ICOL,
    PASS_IROW
  } pass_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN1,
    ST_FIN2
  } state_t;

  typedef struct packed {
    pass_t             pass;
    logic [POS_W-1:0]  pos;
    logic [SIDE_W-1:0] tap;
    logic              issue;
    logic              first;
    logic              fin1;
    logic              fin2;
    logic              in_we;
    logic [POS_W-1:0]  in_addr;
  } dhfs_cmd_t;

  typedef struct packed {
    logic out_free;
  } dhfs_stat_t;

  // cos(m*pi/16), Q30, m = 0..8
  localparam logic [31:0] COS_Q30 [0:8] = '{
    32'd1073741824, 32'd1053110176, 32'd992008094, 32'd892783698, 32'd759250125,
    32'd596538995,  32'd410903207,  32'd209476638, 32'd0
  };

  // cos(j*pi/16) at COS_FRAC_BITS fraction bits
  function automatic logic signed [COEF_W-1:0] cos_q(input logic [4:0] j);
    logic [4:0]               mm;
    logic                     neg;
    logic [31:0]              mag;
    logic signed [COEF_W-1:0] v;
    if (j <= 5'd8) begin
      mm  = j;
      neg = 1'b0;
    end else if (j <= 5'd16) begin
      mm  = 5'd16 - j;
      neg = 1'b1;
    end else if (j <= 5'd24) begin
      mm  = j - 5'd16;
      neg = 1'b1;
    end else begin
      mm  = 5'd0 - j;
      neg = 1'b0;
    end
    mag = (COS_Q30[mm[3:0]] + (32'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
    v = signed'(mag[COEF_W-1:0]);
    return neg ? -v : v;
  endfunction

  // basis entry for frequency k at position x
  function automatic logic signed [COEF_W-1:0] basis(input logic [SIDE_W-1:0] k,
                                                     input logic [SIDE_W-1:0] x);
    logic [7:0] p;
    logic [4:0] j;
    p = 8'({x, 1'b1}) * 8'(k);
    j = (k == '0) ? 5'd4 : p[4:0];
    return cos_q(j);
  endfunction

endpackage

`default_nettype wire

@@ src/dct_block_high_frequency_smoothing_unit.sv @@
// Takes in a block of 64 samples, then runs 4 passes x 64 coefficients on
// the single shared multiply-accumulate unit: 8 taps, one read drain and
// two finish steps per coefficient. The final finish step waits while the
// output is stalled. A new block is taken only once the previous one is done.
// Reset clears the sample count, sequencer and output valid; registers go to 154.
`default_nettype none

module dct_block_high_frequency_smoothing_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dhfs_pkg::PIX_W-1:0]     pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dhfs_pkg::PIX_W-1:0]     pixel_out,
  output logic                           block_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dhfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dhfs_pkg::CFG_W-1:0]     cfg_data
);
  import dhfs_pkg::*;

  dhfs_cmd_t  cmd;
  dhfs_stat_t stat;

  assign cfg_ready = 1'b1;

  dhfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dhfs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .pixel_in  (pixel_in),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pixel_out (pixel_out),
    .block_end (block_end)
  );

endmodule

`default_nettype wire

@@ src/dhfs_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module dhfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/dhfs_ctrl.sv @@
// Sequencer: sample counting, pass/coefficient/tap counters, MAC and
// finish commands. Depends on dhfs_pkg.
`default_nettype none

module dhfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dhfs_pkg::dhfs_stat_t stat,
  output dhfs_pkg::dhfs_cmd_t  cmd
);
  import dhfs_pkg::*;

  state_t            state, state_next;
  pass_t             pass, pass_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [SIDE_W-1:0] tap, tap_next;
  logic [POS_W-1:0]  cnt, cnt_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= PASS_ROW;
      pos   <= '0;
      tap   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      pos   <= pos_next;
      tap   <= tap_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    pass_next   = pass;
    pos_next    = pos;
    tap_next    = tap;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.pass    = pass;
    cmd.pos     = pos;
    cmd.tap     = tap;
    cmd.in_addr = cnt;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.in_we = in_valid;
        if (in_valid) begin
          cnt_next = cnt + 1'b1;
          if (cnt == POS_W'(BLOCK_AREA - 1)) begin
            state_next = ST_RUN;
            pass_next  = PASS_ROW;
            pos_next   = '0;
            tap_next   = '0;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        cmd.first = (tap == '0);
        tap_next  = tap + 1'b1;
        if (tap == SIDE_W'(BLOCK_SIDE - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN1;
      end
      ST_FIN1: begin
        cmd.fin1   = 1'b1;
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        if (pass != PASS_IROW || stat.out_free) begin
          cmd.fin2 = 1'b1;
          pos_next = pos + 1'b1;
          if (pos == POS_W'(BLOCK_AREA - 1)) begin
            if (pass == PASS_IROW) begin
              state_next = ST_IDLE;
            end else begin
              pass_next  = pass_t'(2'(pass) + 2'd1);
              state_next = ST_RUN;
            end
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/dhfs_dpath.sv @@
// Datapath: sample and coefficient stores, shared multiply-accumulate,
// rounding, high-frequency scaling, blend and output register.
// Depends on dhfs_pkg and dhfs_ram.
`default_nettype none

module dhfs_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  dhfs_pkg::dhfs_cmd_t           cmd,
  output dhfs_pkg::dhfs_stat_t          stat,
  input  logic [dhfs_pkg::PIX_W-1:0]    pixel_in,
  input  logic                          cfg_valid,
  input  logic [dhfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dhfs_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [dhfs_pkg::PIX_W-1:0]    pixel_out,
  output logic                          block_end
);
  import dhfs_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF_ROW = ACC_W'(1) <<< (SH_ROW - 1);
  localparam logic signed [ACC_W-1:0] HALF_COL = ACC_W'(1) <<< (SH_COL - 1);
  localparam logic signed [ACC_W-1:0] HALF_INV = ACC_W'(1) <<< (SH_INV - 1);
  localparam int SPROD_W = WORK_W + CFG_W + 1;
  localparam int SM_W    = PIX_W + GUARD_BITS + 1;
  localparam int MIX_W   = 32;

  logic [CFG_W-1:0] hf_scale;
  logic [CFG_W-1:0] blend;

  logic [SIDE_W-1:0] a, b, k;
  logic [PIX_W-1:0]  orig_rd;
  logic [WORK_W-1:0] a_rd, b_rd;
  logic [POS_W-1:0]  orig_raddr, a_raddr;
  logic              a_we, b_we;
  logic [WORK_W-1:0] res;

  logic signed [COEF_W-1:0] coef, coef_q;
  logic signed [WORK_W-1:0] src;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     issue_d, first_d;
  logic signed [WORK_W-1:0] d_q, d_next;

  logic signed [ACC_W-1:0]   r_row, r_col, r_inv, sm_full;
  logic signed [SPROD_W-1:0] sprod, sprod_r;
  logic                      hi_freq;
  logic signed [CFG_W:0]     w_orig, w_sm;
  logic signed [MIX_W-1:0]   mix, mix_r;
  logic [PIX_W-1:0]          pix;

  assign a = cmd.pos[POS_W-1:SIDE_W];
  assign b = cmd.pos[SIDE_W-1:0];
  assign k = cmd.tap;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hf_scale <= CFG_RESET;
      blend    <= CFG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HF_SCALE) begin
        hf_scale <= cfg_data;
      end else if (cfg_index == REG_BLEND) begin
        blend <= cfg_data;
      end
    end
  end

  // store addressing
  assign orig_raddr = (cmd.pass == PASS_ROW) ? {a, k} : cmd.pos;
  assign a_raddr    = (cmd.pass == PASS_COL) ? {k, b} : {a, k};
  assign a_we       = cmd.fin2 && (cmd.pass == PASS_ROW || cmd.pass == PASS_ICOL);
  assign b_we       = cmd.fin2 && (cmd.pass == PASS_COL);

  dhfs_ram #(.WIDTH(PIX_W), .DEPTH(BLOCK_AREA)) u_orig (
    .clk   (clk),
    .we    (cmd.in_we),
    .waddr (cmd.in_addr),
    .wdata (pixel_in),
    .raddr (orig_raddr),
    .rdata (orig_rd)
  );

  dhfs_ram #(.WIDTH(WORK_W), .DEPTH(BLOCK_AREA)) u_work_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (cmd.pos),
    .wdata (res),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  dhfs_ram #(.WIDTH(WORK_W), .DEPTH(BLOCK_AREA)) u_work_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (cmd.pos),
    .wdata (res),
    .raddr ({k, b}),
    .rdata (b_rd)
  );

  // basis coefficient for this tap
  always_comb begin
    unique case (cmd.pass)
      PASS_ROW:  coef = basis(b, k);
      PASS_COL:  coef = basis(a, k);
      PASS_ICOL: coef = basis(k, a);
      PASS_IROW: coef = basis(k, b);
      default:   coef = '0;
    endcase
  end

  // MAC operand from the store of the current pass
  always_comb begin
    case (cmd.pass)
      PASS_ROW:  src = signed'(WORK_W'(orig_rd)) - WORK_W'(128);
      PASS_ICOL: src = signed'(b_rd);
      default:   src = signed'(a_rd);
    endcase
  end

  assign prod = src * coef_q;

  // multiply-accumulate, one tap per cycle behind the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_d <= 1'b0;
      first_d <= 1'b0;
    end else begin
      issue_d <= cmd.issue;
      first_d <= cmd.first;
    end
    coef_q <= coef;
    if (issue_d) begin
      acc <= first_d ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // first finish step: round the sum (in the last pass also level shift and clamp)
  assign r_row   = (acc + HALF_ROW) >>> SH_ROW;
  assign r_col   = (acc + HALF_COL) >>> SH_COL;
  assign r_inv   = (acc + HALF_INV) >>> SH_INV;
  assign sm_full = r_inv + (ACC_W'(128) <<< GUARD_BITS);

  always_comb begin
    case (cmd.pass)
      PASS_ROW:  d_next = r_row[WORK_W-1:0];
      PASS_COL:  d_next = r_col[WORK_W-1:0];
      PASS_ICOL: d_next = r_inv[WORK_W-1:0];
      default: begin
        // level shift and clamp to 0..255 in Q.4
        if (sm_full < 0) begin
          d_next = '0;
        end else if (sm_full > (ACC_W'(255) <<< GUARD_BITS)) begin
          d_next = WORK_W'(255) <<< GUARD_BITS;
        end else begin
          d_next = sm_full[WORK_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      d_q <= d_next;
    end
  end

  // second finish step: high-frequency scaling in the column pass
  assign hi_freq = (({1'b0, a} + {1'b0, b}) >= (SIDE_W + 1)'(BLOCK_SIDE));
  assign sprod   = SPROD_W'(d_q) * signed'({1'b0, hf_scale});
  assign sprod_r = (sprod + SPROD_W'(128)) >>> 8;

  always_comb begin
    if (cmd.pass == PASS_COL && hi_freq) begin
      res = sprod_r[WORK_W-1:0];
    end else begin
      res = d_q;
    end
  end

  // blend with the original sample
  assign w_sm   = signed'({1'b0, blend});
  assign w_orig = (CFG_W + 1)'(256) - w_sm;
  assign mix    = ((MIX_W'(signed'({1'b0, orig_rd})) * MIX_W'(w_orig)) <<< GUARD_BITS)
                + MIX_W'(signed'(d_q[SM_W-1:0])) * MIX_W'(w_sm);
  assign mix_r  = (mix + (MIX_W'(1) <<< (7 + GUARD_BITS))) >>> (8 + GUARD_BITS);

  always_comb begin
    if (mix_r < 0) begin
      pix = '0;
    end else if (mix_r > MIX_W'(255)) begin
      pix = 8'd255;
    end else begin
      pix = mix_r[PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin2 && cmd.pass == PASS_IROW) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.fin2 && cmd.pass == PASS_IROW) begin
      pixel_out <= pix;
      block_end <= (cmd.pos == POS_W'(BLOCK_AREA - 1));
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ src/dhfs_checker.sv @@
// Port-level checks for the smoothing block, bound to the top level.
// Depends on dhfs_pkg.
`default_nettype none

module dhfs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [dhfs_pkg::PIX_W-1:0]     pixel_in,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [dhfs_pkg::PIX_W-1:0]     pixel_out,
  input logic                           block_end,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [dhfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [dhfs_pkg::CFG_W-1:0]     cfg_data
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(block_end))
    else $error("result dropped or changed while stalled");

  // after reset, no result and ready for samples
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // nothing follows the last result of a block until a new block arrives
  a_block_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && block_end |=> !out_valid)
    else $error("result after end of block");

  // no results while samples are being taken in, except the pending last one
  a_no_mix: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared during sample intake");

endmodule

bind dct_block_high_frequency_smoothing_unit dhfs_checker u_dhfs_checker (.*);

`default_nettype wire
